### hdl/fbac_pkg.sv
`timescale 1ns / 1ps

package fbac_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 64;

    localparam int FLOW_KEY_W = 64;
    localparam int SIZE_W     = 16;
    localparam int TIME_W     = 32;
    localparam int BYTES_W    = 40;
    localparam int TOTAL_W    = 48;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

    localparam logic [TOTAL_W:0] BYTES_MAX = {{(TOTAL_W - BYTES_W + 1){1'b0}}, {BYTES_W{1'b1}}};
    localparam logic [TOTAL_W:0] TOTAL_MAX = {1'b0, {TOTAL_W{1'b1}}};

    typedef enum logic
    {
        ALU_ADD_BYTES,
        ALU_ADD_TOTAL
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t            op;
        logic [TOTAL_W-1:0] a;
        logic [TOTAL_W-1:0] b;
    } alu_req_t;

    typedef struct packed
    {
        logic [TOTAL_W-1:0] sum;
        logic               a_zero;
    } alu_rsp_t;

endpackage

### hdl/fbac_alu.sv
`timescale 1ns / 1ps

module fbac_alu
(
    input  fbac_pkg::alu_req_t req,
    output fbac_pkg::alu_rsp_t rsp
);

    logic [fbac_pkg::TOTAL_W:0] full;
    logic [fbac_pkg::TOTAL_W:0] limit;

    always_comb
    begin
        full  = {1'b0, req.a} + {1'b0, req.b};
        limit = (req.op == fbac_pkg::ALU_ADD_BYTES) ? fbac_pkg::BYTES_MAX : fbac_pkg::TOTAL_MAX;
        rsp.sum    = (full > limit) ? limit[fbac_pkg::TOTAL_W-1:0]
                                    : full[fbac_pkg::TOTAL_W-1:0];
        rsp.a_zero = (req.a == '0);
    end

endmodule

### hdl/fbac_table.sv
`timescale 1ns / 1ps

module fbac_table
#(
    parameter int DEPTH = fbac_pkg::TABLE_DEPTH_DEF,
    parameter int DW    = fbac_pkg::KEY_WIDTH_DEF + fbac_pkg::BYTES_W + fbac_pkg::TIME_W,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  logic [DW-1:0]    wdata,
    input  logic             re,
    input  logic [IW-1:0]    raddr,
    output logic [DW-1:0]    rdata,
    input  logic             vset,
    input  logic             vclr,
    input  logic [IW-1:0]    vidx,
    output logic [DEPTH-1:0] valid
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DW-1:0]    rdata_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (vset)
        begin
            valid_reg[vidx] <= 1'b1;
        end
        else if (vclr)
        begin
            valid_reg[vidx] <= 1'b0;
        end
    end

    assign rdata = rdata_reg;
    assign valid = valid_reg;

endmodule

### hdl/fbac_ctrl.sv
`timescale 1ns / 1ps

module fbac_ctrl
#(
    parameter int TABLE_DEPTH = fbac_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = fbac_pkg::KEY_WIDTH_DEF,
    parameter int DW          = KEY_WIDTH + fbac_pkg::BYTES_W + fbac_pkg::TIME_W,
    parameter int IW          = $clog2(TABLE_DEPTH),
    parameter int OCC_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [fbac_pkg::FLOW_KEY_W-1:0]   flow_key,
    input  logic [fbac_pkg::SIZE_W-1:0]       byte_count,
    input  logic [fbac_pkg::TIME_W-1:0]       now,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fbac_pkg::KIND_W-1:0]       kind,
    output logic [fbac_pkg::FLOW_KEY_W-1:0]   rec_key,
    output logic [fbac_pkg::BYTES_W-1:0]      rec_bytes,
    output logic [fbac_pkg::TIME_W-1:0]       rec_start,
    output logic [fbac_pkg::TIME_W-1:0]       rec_end,
    output logic [OCC_W-1:0]                  occupancy,
    output logic [fbac_pkg::TOTAL_W-1:0]      grand_total,
    output logic                              dropped,
    output logic                              last,
    // table
    output logic                              t_we,
    output logic [IW-1:0]                     t_waddr,
    output logic [DW-1:0]                     t_wdata,
    output logic                              t_re,
    output logic [IW-1:0]                     t_raddr,
    input  logic [DW-1:0]                     t_rdata,
    output logic                              t_vset,
    output logic                              t_vclr,
    output logic [IW-1:0]                     t_vidx,
    input  logic [TABLE_DEPTH-1:0]            t_valid,
    // shared adder
    output fbac_pkg::alu_req_t                alu_req,
    input  fbac_pkg::alu_rsp_t                alu_rsp
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_P_RD,
        S_P_CK,
        S_P_END,
        S_P_ACK,
        S_FE_RD,
        S_FE_CK,
        S_FX_RD,
        S_FX_CK,
        S_F_SUM
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    state_t                          state_reg, state_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [IW-1:0]                   free_idx_reg, free_idx_next;
    logic                            free_found_reg, free_found_next;
    logic                            drop_reg, drop_next;
    logic [KEY_WIDTH-1:0]            key_reg, key_next;
    logic [fbac_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [fbac_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [OCC_W-1:0]                occ_reg, occ_next;
    logic [fbac_pkg::TOTAL_W-1:0]    total_reg, total_next;

    logic                            out_valid_reg, out_valid_next;
    logic [fbac_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [fbac_pkg::FLOW_KEY_W-1:0] rec_key_reg, rec_key_next;
    logic [fbac_pkg::BYTES_W-1:0]    rec_bytes_reg, rec_bytes_next;
    logic [fbac_pkg::TIME_W-1:0]     rec_start_reg, rec_start_next;
    logic [fbac_pkg::TIME_W-1:0]     rec_end_reg, rec_end_next;
    logic [OCC_W-1:0]                occ_out_reg, occ_out_next;
    logic [fbac_pkg::TOTAL_W-1:0]    total_out_reg, total_out_next;
    logic                            drop_out_reg, drop_out_next;
    logic                            last_reg, last_next;

    logic [KEY_WIDTH-1:0]            rkey;
    logic [fbac_pkg::BYTES_W-1:0]    rbytes;
    logic [fbac_pkg::TIME_W-1:0]     rstart;
    logic                            slot_free;
    logic                            at_last;

    assign rkey   = t_rdata[DW-1 -: KEY_WIDTH];
    assign rbytes = t_rdata[fbac_pkg::BYTES_W + fbac_pkg::TIME_W - 1 -: fbac_pkg::BYTES_W];
    assign rstart = t_rdata[fbac_pkg::TIME_W-1:0];

    // output register can take a new result this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign at_last   = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        drop_next       = drop_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        now_next        = now_reg;
        occ_next        = occ_reg;
        total_next      = total_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        rec_key_next    = rec_key_reg;
        rec_bytes_next  = rec_bytes_reg;
        rec_start_next  = rec_start_reg;
        rec_end_next    = rec_end_reg;
        occ_out_next    = occ_out_reg;
        total_out_next  = total_out_reg;
        drop_out_next   = drop_out_reg;
        last_next       = last_reg;

        t_we    = 1'b0;
        t_waddr = idx_reg;
        t_wdata = {rkey, rbytes, rstart};
        t_re    = 1'b0;
        t_raddr = idx_reg;
        t_vset  = 1'b0;
        t_vclr  = 1'b0;
        t_vidx  = idx_reg;

        alu_req.op = fbac_pkg::ALU_ADD_TOTAL;
        alu_req.a  = total_reg;
        alu_req.b  = fbac_pkg::TOTAL_W'(rbytes);
        if (state_reg == S_P_CK)
        begin
            alu_req.op = fbac_pkg::ALU_ADD_BYTES;
            alu_req.a  = fbac_pkg::TOTAL_W'(rbytes);
            alu_req.b  = fbac_pkg::TOTAL_W'(size_reg);
        end
        else if (state_reg == S_FE_CK)
        begin
            alu_req.a  = fbac_pkg::TOTAL_W'(rbytes);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = flow_key[KEY_WIDTH-1:0];
                    size_next       = byte_count;
                    now_next        = now;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    drop_next       = 1'b0;
                    state_next      = func ? S_FE_RD : S_P_RD;
                end
            end

            S_P_RD:
            begin
                if (t_valid[idx_reg])
                begin
                    t_re       = 1'b1;
                    state_next = S_P_CK;
                end
                else
                begin
                    if (!free_found_reg)
                    begin
                        free_idx_next   = idx_reg;
                        free_found_next = 1'b1;
                    end
                    if (at_last)
                    begin
                        state_next = S_P_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_P_CK:
            begin
                if (rkey == key_reg)
                begin
                    t_we       = 1'b1;
                    t_wdata    = {rkey, alu_rsp.sum[fbac_pkg::BYTES_W-1:0], rstart};
                    state_next = S_P_ACK;
                end
                else if (at_last)
                begin
                    state_next = S_P_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end

            S_P_END:
            begin
                if (free_found_reg)
                begin
                    t_we    = 1'b1;
                    t_waddr = free_idx_reg;
                    t_wdata = {key_reg, fbac_pkg::BYTES_W'(size_reg), now_reg};
                    t_vset  = 1'b1;
                    t_vidx  = free_idx_reg;
                    occ_next = occ_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                state_next = S_P_ACK;
            end

            S_P_ACK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = fbac_pkg::KIND_ACK;
                    rec_key_next   = '0;
                    rec_bytes_next = '0;
                    rec_start_next = '0;
                    rec_end_next   = '0;
                    occ_out_next   = occ_reg;
                    total_out_next = total_reg;
                    drop_out_next  = drop_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // first pass: evict entries that counted nothing
            S_FE_RD:
            begin
                if (t_valid[idx_reg])
                begin
                    t_re       = 1'b1;
                    state_next = S_FE_CK;
                end
                else if (at_last)
                begin
                    idx_next   = '0;
                    state_next = S_FX_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_FE_CK:
            begin
                if (alu_rsp.a_zero)
                begin
                    t_vclr   = 1'b1;
                    occ_next = occ_reg - 1'b1;
                end
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = S_FX_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FE_RD;
                end
            end

            // second pass: export survivors
            S_FX_RD:
            begin
                if (t_valid[idx_reg])
                begin
                    t_re       = 1'b1;
                    state_next = S_FX_CK;
                end
                else if (at_last)
                begin
                    state_next = S_F_SUM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_FX_CK:
            begin
                if (slot_free)
                begin
                    total_next     = alu_rsp.sum;
                    t_we           = 1'b1;
                    t_wdata        = {rkey, {fbac_pkg::BYTES_W{1'b0}}, now_reg};
                    out_valid_next = 1'b1;
                    kind_next      = fbac_pkg::KIND_REC;
                    rec_key_next   = fbac_pkg::FLOW_KEY_W'(rkey);
                    rec_bytes_next = rbytes;
                    rec_start_next = rstart;
                    rec_end_next   = now_reg;
                    occ_out_next   = occ_reg;
                    total_out_next = alu_rsp.sum;
                    drop_out_next  = 1'b0;
                    last_next      = 1'b0;
                    if (at_last)
                    begin
                        state_next = S_F_SUM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FX_RD;
                    end
                end
            end

            S_F_SUM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = fbac_pkg::KIND_SUM;
                    rec_key_next   = '0;
                    rec_bytes_next = '0;
                    rec_start_next = '0;
                    rec_end_next   = now_reg;
                    occ_out_next   = occ_reg;
                    total_out_next = total_reg;
                    drop_out_next  = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            drop_reg       <= 1'b0;
            key_reg        <= '0;
            size_reg       <= '0;
            now_reg        <= '0;
            occ_reg        <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= fbac_pkg::KIND_ACK;
            rec_key_reg    <= '0;
            rec_bytes_reg  <= '0;
            rec_start_reg  <= '0;
            rec_end_reg    <= '0;
            occ_out_reg    <= '0;
            total_out_reg  <= '0;
            drop_out_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_idx_reg   <= free_idx_next;
            free_found_reg <= free_found_next;
            drop_reg       <= drop_next;
            key_reg        <= key_next;
            size_reg       <= size_next;
            now_reg        <= now_next;
            occ_reg        <= occ_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            rec_key_reg    <= rec_key_next;
            rec_bytes_reg  <= rec_bytes_next;
            rec_start_reg  <= rec_start_next;
            rec_end_reg    <= rec_end_next;
            occ_out_reg    <= occ_out_next;
            total_out_reg  <= total_out_next;
            drop_out_reg   <= drop_out_next;
            last_reg       <= last_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign rec_key     = rec_key_reg;
    assign rec_bytes   = rec_bytes_reg;
    assign rec_start   = rec_start_reg;
    assign rec_end     = rec_end_reg;
    assign occupancy   = occ_out_reg;
    assign grand_total = total_out_reg;
    assign dropped     = drop_out_reg;
    assign last        = last_reg;

endmodule

### hdl/flow_byte_accounting_cache_top.sv
`timescale 1ns / 1ps

// Flow byte accounting cache: a fully associative table of TABLE_DEPTH flows
// (key, saturating 40-bit byte count, interval start), walked one entry at a
// time by a small sequencer around a table memory with separate write and
// read ports and registered read, and one shared saturating adder. A packet
// (func 0) scans entries in index order, reading and comparing each occupied
// entry up to the hit, which updates that entry; on a miss it is written to
// the first free entry, or dropped if none is free; then it is acknowledged.
// A flush (func 1) makes two passes, first evicting zero-count entries, then
// exporting one record per survivor, and closes with a summary; each record
// and the summary wait while the output register is full. in_ready is high
// only between items, rising as the last result is registered; results sit
// in an output register, so the next item is taken while the last result
// still waits. The table is empty after reset.

module flow_byte_accounting_cache_top
#(
    parameter int TABLE_DEPTH = fbac_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = fbac_pkg::KEY_WIDTH_DEF,
    parameter int OCC_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [fbac_pkg::FLOW_KEY_W-1:0] flow_key,
    input  logic [fbac_pkg::SIZE_W-1:0]     byte_count,
    input  logic [fbac_pkg::TIME_W-1:0]     now,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fbac_pkg::KIND_W-1:0]     kind,
    output logic [fbac_pkg::FLOW_KEY_W-1:0] rec_key,
    output logic [fbac_pkg::BYTES_W-1:0]    rec_bytes,
    output logic [fbac_pkg::TIME_W-1:0]     rec_start,
    output logic [fbac_pkg::TIME_W-1:0]     rec_end,
    output logic [OCC_W-1:0]                occupancy,
    output logic [fbac_pkg::TOTAL_W-1:0]    grand_total,
    output logic                            dropped,
    output logic                            last
);

    localparam int DW = KEY_WIDTH + fbac_pkg::BYTES_W + fbac_pkg::TIME_W;
    localparam int IW = $clog2(TABLE_DEPTH);

    logic                   t_we;
    logic [IW-1:0]          t_waddr;
    logic [DW-1:0]          t_wdata;
    logic                   t_re;
    logic [IW-1:0]          t_raddr;
    logic [DW-1:0]          t_rdata;
    logic                   t_vset;
    logic                   t_vclr;
    logic [IW-1:0]          t_vidx;
    logic [TABLE_DEPTH-1:0] t_valid;
    fbac_pkg::alu_req_t     alu_req;
    fbac_pkg::alu_rsp_t     alu_rsp;

    fbac_table
    #(
        .DEPTH (TABLE_DEPTH),
        .DW    (DW),
        .IW    (IW)
    )
    u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata),
        .vset  (t_vset),
        .vclr  (t_vclr),
        .vidx  (t_vidx),
        .valid (t_valid)
    );

    fbac_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fbac_ctrl
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .DW          (DW),
        .IW          (IW),
        .OCC_W       (OCC_W)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .flow_key    (flow_key),
        .byte_count  (byte_count),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .rec_key     (rec_key),
        .rec_bytes   (rec_bytes),
        .rec_start   (rec_start),
        .rec_end     (rec_end),
        .occupancy   (occupancy),
        .grand_total (grand_total),
        .dropped     (dropped),
        .last        (last),
        .t_we        (t_we),
        .t_waddr     (t_waddr),
        .t_wdata     (t_wdata),
        .t_re        (t_re),
        .t_raddr     (t_raddr),
        .t_rdata     (t_rdata),
        .t_vset      (t_vset),
        .t_vclr      (t_vclr),
        .t_vidx      (t_vidx),
        .t_valid     (t_valid),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp)
    );

endmodule
